### rtl/assert_macros.svh
// Assertion macros used by the motor ramp datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside reset
`define MSRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset
`define MSRR_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define MSRR_ASSERT(lbl, prop, msg)
`define MSRR_NEVER(lbl, expr, msg)

`endif

`endif

### rtl/msrr_pkg.sv
// Types, constants and the speed clamp for the motor ramp block
package msrr_pkg;

  localparam int DUTY_BITS = 8;
  localparam int DUTY_MAX  = (1 << DUTY_BITS) - 1;
  localparam int REQ_W     = 16;
  localparam int RAMP_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W    = RAMP_W + DUTY_BITS;
  localparam int CNT_W     = $clog2(PROD_W);
  localparam int CLAMP_W   = (REQ_W > DUTY_BITS + 1) ? REQ_W : DUTY_BITS + 1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_FWD  = 2'd1,
    OP_BWD  = 2'd2,
    OP_STOP = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SPEED = 2'd0,
    CFG_MAX_SPEED = 2'd1,
    CFG_RAMP_MS   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic exec;      // apply the accepted word to the motor state
    logic mul;       // load elapsed * |target - start| into the divider
    logic div_step;  // one restoring division step
    logic fin;       // write the interpolated duty
    logic load_out;  // capture the result word
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic interp;    // accepted tick needs interpolation
    logic div_done;  // last division step is in progress
    logic out_free;  // result register can take a word this cycle
  } dp_sts_t;

  // Zero or negative gives 0; saturate; raise to min, else cap at max
  function automatic logic [DUTY_BITS-1:0] clamp_speed(
      input logic signed [CLAMP_W-1:0] v,
      input logic [DUTY_BITS-1:0]      lo,
      input logic [DUTY_BITS-1:0]      hi);
    logic [DUTY_BITS-1:0] s;
    if (v[CLAMP_W-1] || (v == '0)) begin
      s = '0;
    end else begin
      if (v > CLAMP_W'(DUTY_MAX)) begin
        s = DUTY_BITS'(DUTY_MAX);
      end else begin
        s = v[DUTY_BITS-1:0];
      end
      if (s < lo) begin
        s = lo;
      end else if (s > hi) begin
        s = hi;
      end
    end
    return s;
  endfunction

endpackage

### rtl/msrr_intf.sv
// Handshake channel interfaces: command words, result words, register writes
interface msrr_cmd_if import msrr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic signed [REQ_W-1:0]  speed_request;

  modport source (output valid, opcode, speed_request, input ready);
  modport sink   (input valid, opcode, speed_request, output ready);
endinterface

interface msrr_res_if import msrr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] pwm_duty;
  logic                 drive_a;
  logic                 drive_b;
  logic                 ramping;
  logic                 moving;

  modport source (output valid, pwm_duty, drive_a, drive_b, ramping, moving, input ready);
  modport sink   (input valid, pwm_duty, drive_a, drive_b, ramping, moving, output ready);
endinterface

interface msrr_cfg_if import msrr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/motor_speed_ramp_reversal.sv
// Top level: H-bridge soft-start drive with linear duty ramps and reversal
// Sequence: forward, backward, stop and non-interpolating ticks go from acceptance straight
//   to the result load; an interpolating tick first takes one multiply, PROD_W = 24
//   restoring divider steps and one duty write. The result load waits for a free result
//   register, and the next word is accepted only after that load.
// Reset (rst_ni low, asynchronous): motor idle, duty 0, pins low, min 0, max 255, ramp 2000.
module motor_speed_ramp_reversal import msrr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  msrr_cmd_if.sink   cmd_i,
  msrr_res_if.source res_o,
  msrr_cfg_if.sink   cfg_i
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Register writes are taken at any time
  assign cfg_i.ready = 1'b1;

  msrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  msrr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (cmd_i.opcode),
    .speed_request_i (cmd_i.speed_request),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .pwm_duty_o      (res_o.pwm_duty),
    .drive_a_o       (res_o.drive_a),
    .drive_b_o       (res_o.drive_b),
    .ramping_o       (res_o.ramping),
    .moving_o        (res_o.moving)
  );

endmodule

### rtl/msrr_ctrl.sv
// Sequencer: accept, multiply, divide, write duty, hand out the result word
module msrr_ctrl import msrr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.interp ? ST_MUL : ST_RESP;
        end
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = ST_RESP;
      ST_RESP: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.exec   = in_valid_i;
      end
      ST_MUL:  cmd_o.mul      = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_FIN:  cmd_o.fin      = 1'b1;
      ST_RESP: cmd_o.load_out = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/msrr_dp.sv
// Motor state, config registers, ramp multiplier and serial divider, result register
`include "assert_macros.svh"

module msrr_dp import msrr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // accepted command word
  input  logic [1:0]               opcode_i,
  input  logic signed [REQ_W-1:0]  speed_request_i,
  // register writes
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DAT_W-1:0]     cfg_data_i,
  // sequencer link
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  // result word
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [DUTY_BITS-1:0]     pwm_duty_o,
  output logic                     drive_a_o,
  output logic                     drive_b_o,
  output logic                     ramping_o,
  output logic                     moving_o
);

  // Configuration
  logic [DUTY_BITS-1:0] min_speed_q;
  logic [DUTY_BITS-1:0] max_speed_q;
  logic [RAMP_W-1:0]    ramp_ms_q;

  // Motor state
  logic [DUTY_BITS-1:0] duty_q, duty_d;
  logic [DUTY_BITS-1:0] start_q, start_d;
  logic [DUTY_BITS-1:0] target_q, target_d;
  logic [RAMP_W-1:0]    elapsed_q, elapsed_d;
  logic                 active_q, active_d;
  logic                 move_q, move_d;
  logic                 rev_q, rev_d;
  logic                 pend_bwd_q, pend_bwd_d;
  logic [DUTY_BITS-1:0] pend_duty_q, pend_duty_d;
  logic                 pin_a_q, pin_a_d;
  logic                 pin_b_q, pin_b_d;

  // Divider
  logic [PROD_W-1:0]    num_q;
  logic [RAMP_W:0]      rem_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 neg_q;

  // Result register
  logic                 out_valid_q;
  logic [DUTY_BITS-1:0] out_duty_q;
  logic                 out_a_q, out_b_q, out_ramp_q, out_move_q;

  logic [RAMP_W-1:0]        el_inc;
  logic                     ramp_end;
  logic [DUTY_BITS-1:0]     req_duty;
  logic [DUTY_BITS-1:0]     end_duty;
  logic                     backward;
  logic                     opposite;
  logic [DUTY_BITS-1:0]     abs_diff;
  logic [RAMP_W:0]          rem_sh;
  logic [RAMP_W:0]          rem_sub;
  logic                     rem_ge;
  logic [DUTY_BITS-1:0]     quot;
  logic signed [CLAMP_W-1:0] interp_v;
  logic [DUTY_BITS-1:0]     interp_duty;
  logic                     out_free;

  // Tick bookkeeping: saturating elapsed count and end of ramp
  assign el_inc   = (elapsed_q == '1) ? elapsed_q : elapsed_q + RAMP_W'(1);
  assign ramp_end = (el_inc >= ramp_ms_q);

  assign req_duty = clamp_speed(CLAMP_W'(speed_request_i), min_speed_q, max_speed_q);
  assign end_duty = clamp_speed(CLAMP_W'(target_q), min_speed_q, max_speed_q);
  assign backward = (op_e'(opcode_i) == OP_BWD);
  assign opposite = backward ? pin_a_q : pin_b_q;

  assign abs_diff = (target_q >= start_q) ? target_q - start_q : start_q - target_q;

  // Restoring division step
  assign rem_sh  = {rem_q[RAMP_W-1:0], num_q[PROD_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, ramp_ms_q});
  assign rem_sub = rem_sh - {1'b0, ramp_ms_q};

  // Interpolated duty, quotient truncated toward zero
  assign quot        = num_q[DUTY_BITS-1:0];
  assign interp_v    = neg_q ? CLAMP_W'(start_q) - CLAMP_W'(quot)
                             : CLAMP_W'(start_q) + CLAMP_W'(quot);
  assign interp_duty = clamp_speed(interp_v, min_speed_q, max_speed_q);

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.interp   = (op_e'(opcode_i) == OP_TICK) && active_q && !ramp_end;
  assign sts_o.div_done = (cnt_q == CNT_W'(PROD_W - 1));
  assign sts_o.out_free = out_free;

  // Motor state next values
  always_comb begin
    duty_d      = duty_q;
    start_d     = start_q;
    target_d    = target_q;
    elapsed_d   = elapsed_q;
    active_d    = active_q;
    move_d      = move_q;
    rev_d       = rev_q;
    pend_bwd_d  = pend_bwd_q;
    pend_duty_d = pend_duty_q;
    pin_a_d     = pin_a_q;
    pin_b_d     = pin_b_q;
    if (cmd_i.exec) begin
      case (op_e'(opcode_i))
        OP_TICK: begin
          if (active_q) begin
            elapsed_d = el_inc;
            if (ramp_end) begin
              duty_d   = end_duty;
              active_d = 1'b0;
              // reversal: swap bridge inputs once stopped, ramp up again
              if (rev_q && (end_duty == '0)) begin
                pin_a_d   = !pend_bwd_q;
                pin_b_d   = pend_bwd_q;
                start_d   = '0;
                target_d  = pend_duty_q;
                elapsed_d = '0;
                active_d  = 1'b1;
                rev_d     = 1'b0;
                move_d    = 1'b1;
              end
            end
          end
        end
        OP_FWD, OP_BWD: begin
          start_d   = duty_q;
          elapsed_d = '0;
          active_d  = 1'b1;
          if ((move_q || active_q) && opposite) begin
            target_d    = '0;
            rev_d       = 1'b1;
            pend_bwd_d  = backward;
            pend_duty_d = req_duty;
          end else begin
            target_d = req_duty;
            pin_a_d  = !backward;
            pin_b_d  = backward;
            move_d   = 1'b1;
          end
        end
        OP_STOP: begin
          if (move_q || (duty_q != '0)) begin
            if (!active_q) begin
              rev_d = 1'b0;
            end
            start_d   = duty_q;
            target_d  = '0;
            elapsed_d = '0;
            active_d  = 1'b1;
            move_d    = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.fin) begin
      duty_d = interp_duty;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q <= '0;
      max_speed_q <= DUTY_BITS'(DUTY_MAX);
      ramp_ms_q   <= RAMP_W'(2000);
      duty_q      <= '0;
      start_q     <= '0;
      target_q    <= '0;
      elapsed_q   <= '0;
      active_q    <= 1'b0;
      move_q      <= 1'b0;
      rev_q       <= 1'b0;
      pend_bwd_q  <= 1'b0;
      pend_duty_q <= '0;
      pin_a_q     <= 1'b0;
      pin_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_MIN_SPEED: min_speed_q <= cfg_data_i[DUTY_BITS-1:0];
          CFG_MAX_SPEED: max_speed_q <= cfg_data_i[DUTY_BITS-1:0];
          CFG_RAMP_MS:   ramp_ms_q   <= cfg_data_i[RAMP_W-1:0];
          default: ;
        endcase
      end
      duty_q      <= duty_d;
      start_q     <= start_d;
      target_q    <= target_d;
      elapsed_q   <= elapsed_d;
      active_q    <= active_d;
      move_q      <= move_d;
      rev_q       <= rev_d;
      pend_bwd_q  <= pend_bwd_d;
      pend_duty_q <= pend_duty_d;
      pin_a_q     <= pin_a_d;
      pin_b_q     <= pin_b_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Multiplier feeds the divider numerator; quotient shifts in from the right
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      num_q <= PROD_W'(elapsed_q) * PROD_W'(abs_diff);
      rem_q <= '0;
      cnt_q <= '0;
      neg_q <= (target_q < start_q);
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[PROD_W-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub : rem_sh;
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // Result word snapshot
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_duty_q <= duty_q;
      out_a_q    <= pin_a_q;
      out_b_q    <= pin_b_q;
      out_ramp_q <= active_q;
      out_move_q <= move_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pwm_duty_o  = out_duty_q;
  assign drive_a_o   = out_a_q;
  assign drive_b_o   = out_b_q;
  assign ramping_o   = out_ramp_q;
  assign moving_o    = out_move_q;

  `MSRR_NEVER(a_pins_exclusive, pin_a_q && pin_b_q, "both bridge inputs high")
  `MSRR_ASSERT(a_div_nonzero, cmd_i.div_step |-> (ramp_ms_q != '0), "divide by zero ramp")
  `MSRR_ASSERT(a_quot_bound, cmd_i.fin |-> (num_q <= PROD_W'(abs_diff)), "quotient beyond span")

endmodule

### sim/tb_top.sv
// Self-checking testbench for the H-bridge soft-start ramp and reversal block
module tb_top;
  import msrr_pkg::*;

  // Result word as seen on the result channel
  typedef struct {
    logic [DUTY_BITS-1:0] duty;
    logic                 drv_a;
    logic                 drv_b;
    logic                 ramping;
    logic                 moving;
  } drive_state_t;

  // Motor drive predictor plus the queue of predicted result words
  class motor_ramp_sb;
    logic [DUTY_BITS-1:0] min_spd = '0;
    logic [DUTY_BITS-1:0] max_spd = DUTY_BITS'(DUTY_MAX);
    logic [RAMP_W-1:0]    ramp_len = 16'd2000;

    logic [DUTY_BITS-1:0] duty, r_start, r_target, rev_duty;
    logic [RAMP_W-1:0]    elapsed;
    logic                 ramp_on, moving, rev_wait, rev_bwd, pin_a, pin_b;

    drive_state_t pending_states[$];
    int           errors;

    function new();
      duty = '0; r_start = '0; r_target = '0; rev_duty = '0; elapsed = '0;
      ramp_on = 0; moving = 0; rev_wait = 0; rev_bwd = 0; pin_a = 0; pin_b = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] value);
      case (idx)
        CFG_MIN_SPEED: min_spd = value[DUTY_BITS-1:0];
        CFG_MAX_SPEED: max_spd = value[DUTY_BITS-1:0];
        CFG_RAMP_MS:   ramp_len = value[RAMP_W-1:0];
        default: ;
      endcase
    endfunction

    // Zero or negative stays zero; saturate; raise to min, else cap at max
    function logic [DUTY_BITS-1:0] limit_duty(int v);
      int s;
      if (v <= 0) return '0;
      s = (v > DUTY_MAX) ? DUTY_MAX : v;
      if (s < int'(min_spd)) s = int'(min_spd);
      else if (s > int'(max_spd)) s = int'(max_spd);
      return s[DUTY_BITS-1:0];
    endfunction

    function void start_ramp(logic [DUTY_BITS-1:0] target);
      r_start = duty;
      r_target = target;
      elapsed = '0;
      ramp_on = 1;
    endfunction

    function void drive_cmd(logic backward, logic [REQ_W-1:0] req);
      logic [DUTY_BITS-1:0] v;
      logic                 opposite;
      v = limit_duty(int'($signed(req)));
      opposite = backward ? pin_a : pin_b;
      // reversal: ramp down first, remember where to go
      if ((moving || ramp_on) && opposite) begin
        start_ramp('0);
        rev_wait = 1;
        rev_bwd = backward;
        rev_duty = v;
        return;
      end
      start_ramp(v);
      pin_a = !backward;
      pin_b = backward;
      moving = 1;
    endfunction

    function void stop_cmd();
      if (!moving && duty == '0) return;
      if (!ramp_on) rev_wait = 0;
      start_ramp('0);
      moving = 0;
    endfunction

    // One millisecond of ramp progress
    function void advance_ms();
      int diff, v;
      if (!ramp_on) return;
      if (elapsed != '1) elapsed++;
      if (elapsed >= ramp_len) begin
        duty = limit_duty(int'(r_target));
        ramp_on = 0;
        // at zero with a reversal waiting: swap pins, ramp up again
        if (rev_wait && duty == '0) begin
          pin_a = !rev_bwd;
          pin_b = rev_bwd;
          r_start = '0;
          r_target = rev_duty;
          elapsed = '0;
          ramp_on = 1;
          rev_wait = 0;
          moving = 1;
        end
        return;
      end
      diff = int'(r_target) - int'(r_start);
      v = (int'(elapsed) * diff) / int'(ramp_len) + int'(r_start);
      duty = limit_duty(v);
    endfunction

    function void take_command(op_e op, logic [REQ_W-1:0] req);
      case (op)
        OP_TICK: advance_ms();
        OP_FWD:  drive_cmd(1'b0, req);
        OP_BWD:  drive_cmd(1'b1, req);
        default: stop_cmd();
      endcase
      pending_states.push_back('{duty, pin_a, pin_b, ramp_on, moving});
    endfunction

    function void cmp(string name, logic [DUTY_BITS-1:0] want, logic [DUTY_BITS-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_state(drive_state_t got);
      drive_state_t want;
      if (pending_states.size() == 0) begin
        $error("result word with no prediction: duty %0d", got.duty);
        errors++;
        return;
      end
      want = pending_states.pop_front();
      cmp("pwm_duty", want.duty, got.duty);
      cmp("drive_a", DUTY_BITS'(want.drv_a), DUTY_BITS'(got.drv_a));
      cmp("drive_b", DUTY_BITS'(want.drv_b), DUTY_BITS'(got.drv_b));
      cmp("ramping", DUTY_BITS'(want.ramping), DUTY_BITS'(got.ramping));
      cmp("moving", DUTY_BITS'(want.moving), DUTY_BITS'(got.moving));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  msrr_cmd_if cmd_if ();
  msrr_res_if res_if ();
  msrr_cfg_if cfg_if ();

  motor_speed_ramp_reversal u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  motor_ramp_sb sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Generous overall limit
  initial begin
    #5000000;
    $display("FAIL motor_speed_ramp_reversal");
    $finish;
  end

  // Result side: long hold-off when asked, else random stalls
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.match_state('{res_if.pwm_duty, res_if.drive_a, res_if.drive_b,
                       res_if.ramping, res_if.moving});
    end
  end

  task automatic send_word(op_e op, logic [REQ_W-1:0] req);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.opcode <= op;
    cmd_if.speed_request <= req;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.take_command(op, req);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  // Speed limits carry random junk in the unused upper byte
  task automatic set_limits(int lo, int hi, int ramp);
    write_reg(CFG_MIN_SPEED, {8'($urandom), 8'(lo)});
    write_reg(CFG_MAX_SPEED, {8'($urandom), 8'(hi)});
    write_reg(CFG_RAMP_MS, 16'(ramp));
  endtask

  // Stop offering words and wait until every prediction is matched
  task automatic settle();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_states.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [REQ_W-1:0] pick_speed();
    case ($urandom_range(0, 4))
      0: return REQ_W'($urandom_range(0, 300));
      1: return REQ_W'($urandom);
      2: return REQ_W'(-$urandom_range(0, 5));
      3: return REQ_W'($urandom_range(1, 30));
      default: return REQ_W'($urandom_range(200, 260));
    endcase
  endfunction

  // Mostly a move command followed by a run of ticks, some loose words
  task automatic run_random(int count);
    int done, n, cap;
    done = 0;
    cap = (sb.ramp_len > 18) ? 40 : 2 * int'(sb.ramp_len) + 3;
    while (done < count) begin
      if ($urandom_range(0, 9) < 7) begin
        send_word($urandom_range(0, 1) ? OP_FWD : OP_BWD, pick_speed());
        n = $urandom_range(0, cap);
        repeat (n) send_word(OP_TICK, REQ_W'($urandom));
        done += n + 1;
      end else begin
        send_word(op_e'(2'($urandom_range(0, 3))), pick_speed());
        done++;
      end
    end
  endtask

  initial begin
    int lo, hi, ramp;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    rst_ni = 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.opcode <= OP_TICK;
    cmd_if.speed_request <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_MIN_SPEED;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle words, full-scale requests, reversals, stop during ramp
    set_limits(0, 255, 4);
    send_word(OP_TICK, 16'h0);
    send_word(OP_STOP, 16'h0);
    send_word(OP_FWD, 16'h7FFF);
    repeat (2) send_word(OP_TICK, 16'hFFFF);
    send_word(OP_BWD, 16'h8000);
    send_word(OP_FWD, 16'd50);
    send_word(OP_BWD, 16'd300);
    send_word(OP_STOP, 16'h0);
    repeat (5) send_word(OP_TICK, 16'h0);
    send_word(OP_STOP, 16'h0);
    repeat (5) send_word(OP_TICK, 16'h0);
    send_word(OP_FWD, 16'h0);
    send_word(OP_FWD, 16'hFFFF);
    settle();
    // min above max, zero ramp length
    set_limits(200, 100, 0);
    send_word(OP_BWD, 16'd10);
    send_word(OP_TICK, 16'h0);
    send_word(OP_BWD, 16'd150);
    send_word(OP_TICK, 16'h0);
    send_word(OP_STOP, 16'h0);
    settle();

    // Random phases over several register settings and idle patterns
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin lo = 0;   hi = 255; ramp = 8;     end
        1: begin lo = 255; hi = 255; ramp = 0;     end
        2: begin lo = 0;   hi = 0;   ramp = 3;     end
        3: begin lo = 200; hi = 50;  ramp = 16;    end
        4: begin lo = $urandom_range(0, 255); hi = $urandom_range(0, 255); ramp = 65535; end
        5: begin lo = $urandom_range(0, 100); hi = $urandom_range(150, 255);
                 ramp = $urandom_range(1, 30); end
        6: begin lo = 10;  hi = 240; ramp = 2000;  end
        default: begin lo = 0; hi = 255; ramp = 1; end
      endcase
      set_limits(lo, hi, ramp);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      // back-pressure: result side held off while words keep coming
      if (p == 0) begin
        hold_left = 300;
        run_random(24);
      end
      run_random(100);
      settle();
    end

    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_states.size() == 0) begin
      $display("PASS motor_speed_ramp_reversal");
    end else begin
      if (sb.pending_states.size() != 0)
        $error("%0d predicted result words never arrived", sb.pending_states.size());
      $display("FAIL motor_speed_ramp_reversal");
    end
    $finish;
  end

endmodule
